// ===== sv/ppf_pkg.sv =====
package ppf_pkg;
  localparam int NORM_WIDTH = 16;
  localparam int COS_WIDTH  = 16;
  localparam int DIST_WIDTH = 17;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
  localparam logic [COS_WIDTH-1:0] COS_POS_MAX = {1'b0, {(COS_WIDTH-1){1'b1}}};
  localparam logic [COS_WIDTH-1:0] COS_NEG_MAX = {1'b1, {(COS_WIDTH-1){1'b0}}};
endpackage

// ===== sv/ppf_sqrt.sv =====
// pipelined floor square root, one result bit per stage
module ppf_sqrt import ppf_pkg::*; #(
  parameter int IN_WIDTH = 34,
  parameter int TAG_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [IN_WIDTH-1:0]           radicand,
  input  logic [TAG_WIDTH-1:0]          in_tag,
  output logic                          out_valid,
  output logic [(IN_WIDTH+1)/2-1:0]     root,
  output logic [TAG_WIDTH-1:0]          out_tag
);
  localparam int RW = (IN_WIDTH + 1) / 2;
  localparam int SW = 2 * RW;

  logic [RW:0]          vld;
  logic [SW-1:0]        rem   [RW+1];
  logic [RW-1:0]        res   [RW+1];
  logic [TAG_WIDTH-1:0] tag   [RW+1];

  assign vld[0] = in_valid;
  assign rem[0] = SW'(radicand);
  assign res[0] = '0;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic [SW-1:0] trial;
    logic [SW-1:0] sq;
    logic [RW-1:0] cand;
    always_comb begin
      cand  = res[s] | (RW'(1) << B);
      // cand^2 - res^2 = 2*res*2^B + 2^2B, no multiplier needed
      trial = (SW'(res[s]) << (B + 1)) | (SW'(1) << (2 * B));
      sq    = trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tag[s+1] <= tag[s];
      if (rem[s] >= sq) begin
        rem[s+1] <= rem[s] - sq;
        res[s+1] <= cand;
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = res[RW];
  assign out_tag   = tag[RW];
endmodule

// ===== sv/ppf_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ppf_div import ppf_pkg::*; #(
  parameter int NUM_WIDTH = 36,
  parameter int DEN_WIDTH = 18,
  parameter int TAG_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [NUM_WIDTH-1:0]  num,
  input  logic [DEN_WIDTH-1:0]  den,
  input  logic [TAG_WIDTH-1:0]  in_tag,
  output logic                  out_valid,
  output logic [NUM_WIDTH-1:0]  quo,
  output logic [TAG_WIDTH-1:0]  out_tag
);
  localparam int RW = DEN_WIDTH + 1;

  logic [NUM_WIDTH:0]   vld;
  logic [NUM_WIDTH-1:0] q   [NUM_WIDTH+1];
  logic [RW-1:0]        r   [NUM_WIDTH+1];
  logic [DEN_WIDTH-1:0] dv  [NUM_WIDTH+1];
  logic [TAG_WIDTH-1:0] tag [NUM_WIDTH+1];

  assign vld[0] = in_valid;
  assign q[0]   = num;
  assign r[0]   = '0;
  assign dv[0]  = den;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
    logic [RW-1:0] sh;
    assign sh = {r[s][RW-2:0], q[s][NUM_WIDTH-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tag[s+1] <= tag[s];
      dv[s+1]  <= dv[s];
      if (sh >= RW'(dv[s])) begin
        r[s+1] <= sh - RW'(dv[s]);
        q[s+1] <= {q[s][NUM_WIDTH-2:0], 1'b1};
      end else begin
        r[s+1] <= sh;
        q[s+1] <= {q[s][NUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[NUM_WIDTH];
  assign quo       = q[NUM_WIDTH];
  assign out_tag   = tag[NUM_WIDTH];
endmodule

// ===== sv/point_pair_feature.sv =====
// throughput: one item per cycle; busy is always low after reset
// the sqrt and two dividers are bit-per-stage pipelines and set the depth
// reset (rst, synchronous) clears all valid bits; no result follows reset
module point_pair_feature import ppf_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [NORM_WIDTH-1:0]  first_nx,
  input  logic signed [NORM_WIDTH-1:0]  first_ny,
  input  logic signed [NORM_WIDTH-1:0]  first_nz,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [NORM_WIDTH-1:0]  second_nx,
  input  logic signed [NORM_WIDTH-1:0]  second_ny,
  input  logic signed [NORM_WIDTH-1:0]  second_nz,
  output logic                          done,
  output logic signed [COS_WIDTH-1:0]   cos_first_dir,
  output logic signed [COS_WIDTH-1:0]   cos_second_dir,
  output logic signed [COS_WIDTH-1:0]   cos_normals,
  output logic [DIST_WIDTH-1:0]         pair_distance
);
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SQW = PW + 2;
  localparam int RW  = (SQW + 1) / 2;
  localparam int DPW = DW + NORM_WIDTH;
  localparam int DOT_WIDTH = DPW + 2;
  localparam int NPW = 2 * NORM_WIDTH + 2;
  localparam int DIVW = (RW > 1) ? RW : 2;
  // carried alongside the sqrt: signed dots, dotn
  localparam int TW = 2 * DOT_WIDTH + NPW;
  localparam int T2 = 1 + COS_WIDTH + DIST_WIDTH;

  assign busy = 1'b0;

  // stage 1: differences; normals registered alongside
  logic                       v1;
  logic signed [DW-1:0]       dx, dy, dz;
  logic signed [NORM_WIDTH-1:0] a1x, a1y, a1z, a2x, a2y, a2z;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    dx  <= DW'(second_x) - DW'(first_x);
    dy  <= DW'(second_y) - DW'(first_y);
    dz  <= DW'(second_z) - DW'(first_z);
    a1x <= first_nx;  a1y <= first_ny;  a1z <= first_nz;
    a2x <= second_nx; a2y <= second_ny; a2z <= second_nz;
  end

  // stage 2: products
  logic                   v2;
  logic [PW-1:0]          sxx, syy, szz;
  logic signed [DPW-1:0]  p1x, p1y, p1z, p2x, p2y, p2z;
  logic signed [NPW-3:0]  pnx, pny, pnz;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    sxx <= PW'(dx * dx);
    syy <= PW'(dy * dy);
    szz <= PW'(dz * dz);
    p1x <= DPW'(a1x * dx); p1y <= DPW'(a1y * dy); p1z <= DPW'(a1z * dz);
    p2x <= DPW'(a2x * dx); p2y <= DPW'(a2y * dy); p2z <= DPW'(a2z * dz);
    pnx <= (NPW-2)'(a1x * a2x); pny <= (NPW-2)'(a1y * a2y);
    pnz <= (NPW-2)'(a1z * a2z);
  end

  // stage 3: sums
  logic                        v3;
  logic [SQW-1:0]              ssq;
  logic signed [DOT_WIDTH-1:0] dot1, dot2;
  logic signed [NPW-1:0]       dotn;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    ssq  <= SQW'(sxx) + SQW'(syy) + SQW'(szz);
    dot1 <= DOT_WIDTH'(p1x) + DOT_WIDTH'(p1y) + DOT_WIDTH'(p1z);
    dot2 <= DOT_WIDTH'(p2x) + DOT_WIDTH'(p2y) + DOT_WIDTH'(p2z);
    dotn <= NPW'(pnx) + NPW'(pny) + NPW'(pnz);
  end

  // square root
  logic              v4;
  logic [RW-1:0]     pair_dist;
  logic [TW-1:0]     t4;
  ppf_sqrt #(.IN_WIDTH(SQW), .TAG_WIDTH(TW)) u_sqrt (
    .clk, .rst, .in_valid(v3), .radicand(ssq),
    .in_tag({dot1, dot2, dotn}),
    .out_valid(v4), .root(pair_dist), .out_tag(t4)
  );

  logic signed [DOT_WIDTH-1:0] d1s, d2s;
  logic signed [NPW-1:0]       dns;
  logic [DOT_WIDTH-1:0]        m1, m2;
  logic [NPW-1:0]              mn, mns;
  logic [COS_WIDTH-1:0]        cosn;
  logic [DIST_WIDTH-1:0]       dsat;
  always_comb begin
    {d1s, d2s, dns} = t4;
    m1  = d1s[DOT_WIDTH-1] ? DOT_WIDTH'(-d1s) : DOT_WIDTH'(d1s);
    m2  = d2s[DOT_WIDTH-1] ? DOT_WIDTH'(-d2s) : DOT_WIDTH'(d2s);
    mn  = dns[NPW-1] ? NPW'(-dns) : NPW'(dns);
    mns = mn >> NORMAL_FRAC_BITS;
    if (dns[NPW-1]) cosn = (mns > NPW'(32768)) ? COS_NEG_MAX : COS_WIDTH'(-mns);
    else            cosn = (mns > NPW'(32767)) ? COS_POS_MAX : COS_WIDTH'(mns);
    if (DIVW > DIST_WIDTH && DIVW'(pair_dist) > DIVW'(DIST_MAX)) dsat = DIST_MAX;
    else dsat = DIST_WIDTH'(pair_dist);
  end

  logic                 v5a, v5b;
  logic [DOT_WIDTH-1:0] q1, q2;
  logic [T2-1:0]        t5a, t5b;
  logic                 zd;
  assign zd = (pair_dist == '0);
  ppf_div #(.NUM_WIDTH(DOT_WIDTH), .DEN_WIDTH(RW), .TAG_WIDTH(T2)) u_div1 (
    .clk, .rst, .in_valid(v4), .num(m1), .den(pair_dist),
    .in_tag({d1s[DOT_WIDTH-1] & ~zd, cosn, dsat}),
    .out_valid(v5a), .quo(q1), .out_tag(t5a)
  );
  ppf_div #(.NUM_WIDTH(DOT_WIDTH), .DEN_WIDTH(RW), .TAG_WIDTH(T2)) u_div2 (
    .clk, .rst, .in_valid(v4), .num(zd ? '0 : m2), .den(pair_dist),
    .in_tag({d2s[DOT_WIDTH-1] & ~zd, COS_WIDTH'(0), DIST_WIDTH'(zd)}),
    .out_valid(v5b), .quo(q2), .out_tag(t5b)
  );

  function automatic logic [COS_WIDTH-1:0] sat(input logic neg, input logic [DOT_WIDTH-1:0] m);
    if (neg) return (m > DOT_WIDTH'(32768)) ? COS_NEG_MAX : COS_WIDTH'(-m);
    return (m > DOT_WIDTH'(32767)) ? COS_POS_MAX : COS_WIDTH'(m);
  endfunction

  logic zd5;
  assign zd5 = t5b[0];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v5a & v5b;
    cos_first_dir  <= zd5 ? '0 : sat(t5a[T2-1], q1);
    cos_second_dir <= zd5 ? '0 : sat(t5b[T2-1], q2);
    cos_normals    <= t5a[T2-2 -: COS_WIDTH];
    pair_distance  <= t5a[DIST_WIDTH-1:0];
  end
endmodule

// ===== sv/ppf_checker.sv =====
module ppf_checker import ppf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic [DIST_WIDTH-1:0] pair_distance,
  input logic signed [COS_WIDTH-1:0] cos_first_dir,
  input logic signed [COS_WIDTH-1:0] cos_second_dir
);
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy high");
  a_no_done_after_rst: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    done && pair_distance == '0 |-> cos_first_dir == '0 && cos_second_dir == '0)
    else $error("nonzero cosine at zero distance");
endmodule

bind point_pair_feature ppf_checker u_ppf_checker (
  .clk, .rst, .busy, .done, .pair_distance, .cos_first_dir, .cos_second_dir
);
